[rtl/asid_bitmap_allocator_top_macros.svh]
// ----------------------------------------------------------------------------
// ASID bitmap allocator assertion macros
// Shared property forms for the allocator's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASID_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define ASID_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aba_pkg.sv]
// ----------------------------------------------------------------------------
// ASID bitmap allocator package
// Sizes, codes and shared types of the allocator.
// ----------------------------------------------------------------------------
package aba_pkg;

    localparam int NUM_IDS = 65536;
    localparam int ID_W    = 16;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = NUM_IDS / WORD_W;
    localparam int WADDR_W = $clog2(WORDS);
    localparam int CNT_W   = WADDR_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_DONE
    } aba_state_t;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] asid_in;
    } aba_in_t;

    typedef struct packed {
        logic [ID_W-1:0] asid_out;
        logic            ok;
        logic            tlb_invalidate;
        logic [ID_W-1:0] invalidate_asid;
    } aba_out_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic free;
        logic out_load;
    } aba_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic exhausted;
    } aba_sts_t;

endpackage

[rtl/asid_bitmap_allocator_top.sv]
// Allocate: one bitmap word checked per cycle in the scan, from accept to result.
// Free: one read and, for an in-range identifier, one write of the bitmap word.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted.
// After reset a clearing pass writes all 1024 bitmap words, one a cycle, before
// the first request is accepted.
// ----------------------------------------------------------------------------
// ASID bitmap allocator
// Round-robin allocator of address-space identifiers over a used-bit bitmap,
// with a TLB invalidate request for every identifier handed out or freed.
// ----------------------------------------------------------------------------
module asid_bitmap_allocator_top import aba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  aba_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output aba_out_t m_data
);

    aba_cmd_t cmd;
    aba_sts_t sts;

    aba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_data.opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aba_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

[rtl/aba_ctrl.sv]
// ----------------------------------------------------------------------------
// ASID bitmap allocator controller
// Sequences the clearing pass, the bitmap scan, the free update and the
// handoff of each result to the output register.
// ----------------------------------------------------------------------------
module aba_ctrl import aba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_opcode,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  aba_sts_t sts,
    output aba_cmd_t cmd
);

    aba_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_opcode == OP_ALLOC) ? ST_SCAN : ST_FREE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.exhausted) begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE: begin
                cmd.free   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/aba_dp.sv]
// ----------------------------------------------------------------------------
// ASID bitmap allocator datapath
// Holds the used-bit bitmap memory, the next pointer, the word scan with its
// first-free search, and the result and output registers.
// ----------------------------------------------------------------------------
module aba_dp import aba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  aba_cmd_t cmd,
    input  aba_in_t  s_data,
    output aba_sts_t sts,
    output aba_out_t m_data
);

    logic [WORD_W-1:0]  mem [WORDS];
    logic [WORD_W-1:0]  rdata_reg;

    logic [WADDR_W-1:0] addr_reg, addr_next;
    logic [WADDR_W-1:0] chk_word_reg, chk_word_next;
    logic [BIT_W-1:0]   off_reg, off_next;
    logic               first_reg, first_next;
    logic               free_ok_reg, free_ok_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ID_W-1:0]    next_ptr_reg, next_ptr_next;
    aba_out_t           res_reg, res_next;
    aba_out_t           out_reg, out_next;

    logic [WADDR_W-1:0] start_word;
    logic [WADDR_W-1:0] rd_addr;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               we;
    logic [WORD_W-1:0]  low_mask;
    logic [WORD_W-1:0]  zero_mask;
    logic [WORD_W-1:0]  masked;
    logic [WORD_W-1:0]  set_mask;
    logic [WORD_W-1:0]  clr_mask;
    logic [BIT_W-1:0]   hit_idx;
    logic               hit;
    logic               exhausted;
    logic [ID_W-1:0]    found_id;
    logic [ID_W-1:0]    free_id;
    logic               in_range;

    assign start_word = (s_data.opcode == OP_ALLOC) ?
                        WADDR_W'(next_ptr_reg >> BIT_W) :
                        WADDR_W'(s_data.asid_in >> BIT_W);
    assign in_range   = (s_data.asid_in != '0) &&
                        ({1'b0, s_data.asid_in} < (ID_W + 1)'(NUM_IDS));

    assign low_mask  = first_reg ? ((WORD_W'(1) << off_reg) - WORD_W'(1)) : '0;
    assign zero_mask = (chk_word_reg == '0) ? WORD_W'(1) : '0;
    assign masked    = rdata_reg | low_mask | zero_mask;
    assign hit       = ~&masked;
    assign exhausted = !hit && (cnt_reg == CNT_W'(WORDS));

    always_comb begin
        hit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                hit_idx = BIT_W'(i);
            end
        end
    end

    assign set_mask = WORD_W'(1) << hit_idx;
    assign clr_mask = WORD_W'(1) << off_reg;
    assign found_id = ID_W'({chk_word_reg, hit_idx});
    assign free_id  = ID_W'({chk_word_reg, off_reg});

    assign rd_addr = cmd.load ? start_word : addr_reg;
    assign we      = cmd.clr || (cmd.scan && hit) || (cmd.free && free_ok_reg);
    assign wr_addr = cmd.clr ? addr_reg : chk_word_reg;

    always_comb begin
        if (cmd.clr) begin
            wr_data = '0;
        end else if (cmd.scan) begin
            wr_data = rdata_reg | set_mask;
        end else begin
            wr_data = rdata_reg & ~clr_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        addr_next     = addr_reg;
        chk_word_next = chk_word_reg;
        off_next      = off_reg;
        first_next    = first_reg;
        free_ok_next  = free_ok_reg;
        cnt_next      = cnt_reg;
        next_ptr_next = next_ptr_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        if (cmd.clr) begin
            addr_next = addr_reg + WADDR_W'(1);
        end
        if (cmd.load) begin
            chk_word_next = start_word;
            addr_next     = start_word + WADDR_W'(1);
            off_next      = (s_data.opcode == OP_ALLOC) ? next_ptr_reg[BIT_W-1:0] :
                                                          s_data.asid_in[BIT_W-1:0];
            first_next    = 1'b1;
            free_ok_next  = in_range;
            cnt_next      = '0;
        end
        if (cmd.scan) begin
            if (hit) begin
                res_next = '{asid_out: found_id, ok: 1'b1, tlb_invalidate: 1'b1,
                             invalidate_asid: found_id};
                next_ptr_next = (found_id == ID_W'(NUM_IDS - 1)) ? ID_W'(1) :
                                                                 found_id + ID_W'(1);
            end else if (exhausted) begin
                res_next = '0;
            end else begin
                chk_word_next = addr_reg;
                addr_next     = addr_reg + WADDR_W'(1);
                first_next    = 1'b0;
                cnt_next      = cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.free) begin
            if (free_ok_reg) begin
                res_next = '{asid_out: '0, ok: 1'b1, tlb_invalidate: 1'b1,
                             invalidate_asid: free_id};
            end else begin
                res_next = '0;
            end
        end
        if (cmd.out_load) begin
            out_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            next_ptr_reg <= ID_W'(1);
        end else begin
            addr_reg     <= addr_next;
            next_ptr_reg <= next_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_word_reg <= chk_word_next;
        off_reg      <= off_next;
        first_reg    <= first_next;
        free_ok_reg  <= free_ok_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign sts.clr_last  = (addr_reg == WADDR_W'(WORDS - 1));
    assign sts.hit       = hit;
    assign sts.exhausted = exhausted;
    assign m_data        = out_reg;

endmodule

[rtl/aba_checker.sv]
// ----------------------------------------------------------------------------
// ASID bitmap allocator checker
// Port-level checks of the allocator's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "asid_bitmap_allocator_top_macros.svh"

module aba_checker import aba_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input aba_out_t m_data
);

    `ABA_ASSERT_SAME(a_ok_means_inval, aclk, aresetn, m_valid, m_data.ok == m_data.tlb_invalidate, "ok and invalidate disagree")
    `ABA_ASSERT_SAME(a_inval_nonzero, aclk, aresetn, m_valid && m_data.tlb_invalidate, m_data.invalidate_asid != '0, "invalidate of identifier zero")
    `ABA_ASSERT_SAME(a_alloc_consistent, aclk, aresetn, m_valid && (m_data.asid_out != '0), m_data.ok && (m_data.invalidate_asid == m_data.asid_out), "allocated identifier not invalidated")
    `ABA_ASSERT_NEXT(a_beat_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result beat changed")

endmodule

bind asid_bitmap_allocator_top aba_checker u_aba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
